// ===== hw/rtl/interval_scheduling_max_count_top_macros.svh =====
// Assertion macros used by the checker file of the interval scheduler.
// Depends on nothing; take it in with a plain include.
`ifndef INTERVAL_SCHEDULING_MAX_COUNT_TOP_MACROS_SVH
`define INTERVAL_SCHEDULING_MAX_COUNT_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ISMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define ISMC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ismc_pkg.sv =====
// Shared types and constants of the interval scheduler.
// No dependencies.
package ismc_pkg;

    // result count field
    localparam int OUT_W     = 11;
    localparam int COUNT_MAX = 2047;

    // per-cycle command broadcast to every sorter cell
    typedef struct packed {
        logic insert;   // place the new interval in order
        logic pop;      // shift everything one cell toward the head
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        S_LOAD,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

// ===== hw/rtl/ismc_cell.sv =====
// One cell of the insertion-sort chain: holds one interval and a valid bit.
// Depends on ismc_pkg (t_cell_ctrl).
module ismc_cell #(
    parameter int TIME_BITS = 31
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ismc_pkg::t_cell_ctrl  i_ctrl,
    input  logic [TIME_BITS-1:0]  i_new_start,
    input  logic [TIME_BITS-1:0]  i_new_end,
    input  logic                  i_left_valid,
    input  logic                  i_left_after,
    input  logic [TIME_BITS-1:0]  i_left_start,
    input  logic [TIME_BITS-1:0]  i_left_end,
    input  logic                  i_right_valid,
    input  logic [TIME_BITS-1:0]  i_right_start,
    input  logic [TIME_BITS-1:0]  i_right_end,
    output logic                  o_valid,
    output logic [TIME_BITS-1:0]  o_start,
    output logic [TIME_BITS-1:0]  o_end,
    output logic                  o_after
);

    logic                 r_valid;
    logic [TIME_BITS-1:0] r_start;
    logic [TIME_BITS-1:0] r_end;
    logic                 n_valid;
    logic [TIME_BITS-1:0] n_start;
    logic [TIME_BITS-1:0] n_end;
    logic                 after;

    // empty cells sort after everything
    assign after = !r_valid || (r_end > i_new_end) ||
                   ((r_end == i_new_end) && (r_start > i_new_start));

    always_comb begin
        n_valid = r_valid;
        n_start = r_start;
        n_end   = r_end;
        if (i_ctrl.pop) begin
            n_valid = i_right_valid;
            n_start = i_right_start;
            n_end   = i_right_end;
        end else if (i_ctrl.insert && after) begin
            if (i_left_after) begin
                n_valid = i_left_valid;
                n_start = i_left_start;
                n_end   = i_left_end;
            end else begin
                n_valid = 1'b1;
                n_start = i_new_start;
                n_end   = i_new_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_end   <= n_end;
    end

    assign o_valid = r_valid;
    assign o_start = r_start;
    assign o_end   = r_end;
    assign o_after = after;

endmodule

// ===== hw/rtl/ismc_scan.sv =====
// Greedy earliest-finish selector fed by the head of the sorted chain.
// No package dependencies.
module ismc_scan #(
    parameter int TIME_BITS = 31,
    parameter int CNT_W     = 11
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_pop,
    input  logic [TIME_BITS-1:0]  i_head_start,
    input  logic [TIME_BITS-1:0]  i_head_end,
    output logic [CNT_W-1:0]      o_taken
);

    logic                 r_first;
    logic [CNT_W-1:0]     r_taken;
    logic [TIME_BITS-1:0] r_finish;
    logic                 take;

    // first interval always taken; touching intervals allowed
    assign take = i_pop && (r_first || (i_head_start >= r_finish));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
            r_taken <= '0;
        end else if (i_start) begin
            r_first <= 1'b1;
            r_taken <= '0;
        end else if (take) begin
            r_first <= 1'b0;
            r_taken <= r_taken + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_finish <= i_head_end;
        end
    end

    assign o_taken = r_taken;

endmodule

// ===== hw/rtl/interval_scheduling_max_count_top.sv =====
// Interval scheduler top level: insertion-sort cell chain plus greedy scan.
// Depends on ismc_pkg, ismc_cell and ismc_scan.
//
// Counts the most non-overlapping intervals of a set by earliest finish.
// Intervals are loaded one word per cycle into a chain of MAX_INTERVALS
// cells that keeps them ordered by end time, then start time; each cell
// compares its own interval with the new one and either holds, takes its
// left neighbor, or takes the new word. The word carrying i_last closes
// the set: the chain then drains through its head cell one interval per
// cycle into the greedy selector until the chain is found empty, and the
// result is then posted once the output register is free. The input is
// stalled during draining and posting. The result sits in an output
// register, so the next set may already load while it waits. Words
// arriving with a full chain are dropped and flagged in o_overflow; a
// dropped word with i_last still closes the set. The drain empties the
// chain, so no clearing is needed between sets.
module interval_scheduling_max_count_top #(
    parameter int MAX_INTERVALS = 1024,
    parameter int TIME_BITS     = 31
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [TIME_BITS-1:0]          i_start_time,
    input  logic [TIME_BITS-1:0]          i_end_time,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ismc_pkg::OUT_W-1:0]    o_meeting_count,
    output logic                          o_overflow
);

    localparam int CNT_W  = $clog2(MAX_INTERVALS + 1);
    localparam int WIDE_W = (CNT_W > ismc_pkg::OUT_W) ? CNT_W : ismc_pkg::OUT_W;

    ismc_pkg::t_state     r_state;
    ismc_pkg::t_state     n_state;
    logic [CNT_W-1:0]     r_count;       // intervals held in the chain
    logic [CNT_W-1:0]     n_count;
    logic                 r_dropped;
    logic                 n_dropped;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic [ismc_pkg::OUT_W-1:0] r_out_count;
    logic                 r_out_ovf;
    logic                 load_out;

    ismc_pkg::t_cell_ctrl ctrl;
    logic                 accept;
    logic                 full;
    logic                 scan_start;
    logic [CNT_W-1:0]     taken;
    logic [WIDE_W-1:0]    taken_wide;
    logic [ismc_pkg::OUT_W-1:0] taken_sat;

    // chain taps, one per cell
    logic                 c_valid [MAX_INTERVALS];
    logic                 c_after [MAX_INTERVALS];
    logic [TIME_BITS-1:0] c_start [MAX_INTERVALS];
    logic [TIME_BITS-1:0] c_end   [MAX_INTERVALS];

    assign accept = i_valid && !o_stall;
    assign full   = (r_count == CNT_W'(MAX_INTERVALS));

    // FSM: load words, drain the chain into the scanner, post the result
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_dropped   = r_dropped;
        n_out_valid = r_out_valid;
        o_stall     = 1'b1;
        ctrl        = '0;
        scan_start  = 1'b0;
        load_out    = 1'b0;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ismc_pkg::S_LOAD: begin
                o_stall = 1'b0;
                if (accept) begin
                    if (full) begin
                        n_dropped = 1'b1;
                    end else begin
                        ctrl.insert = 1'b1;
                        n_count     = r_count + CNT_W'(1);
                    end
                    if (i_last) begin
                        scan_start = 1'b1;
                        n_state    = ismc_pkg::S_SCAN;
                    end
                end
            end
            ismc_pkg::S_SCAN: begin
                if (r_count != '0) begin
                    ctrl.pop = 1'b1;
                    n_count  = r_count - CNT_W'(1);
                end else begin
                    n_state = ismc_pkg::S_DONE;
                end
            end
            ismc_pkg::S_DONE: begin
                // wait for a free output register
                if (!r_out_valid || !i_stall) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_dropped   = 1'b0;
                    n_state     = ismc_pkg::S_LOAD;
                end
            end
            default: begin
                n_state = ismc_pkg::S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ismc_pkg::S_LOAD;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    // saturate the count to the result field
    assign taken_wide = WIDE_W'(taken);
    assign taken_sat  = (taken_wide > WIDE_W'(ismc_pkg::COUNT_MAX)) ?
                        ismc_pkg::OUT_W'(ismc_pkg::COUNT_MAX) :
                        taken_wide[ismc_pkg::OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_count <= taken_sat;
            r_out_ovf   <= r_dropped;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_meeting_count = r_out_count;
    assign o_overflow      = r_out_ovf;

    // sorter chain: cell 0 is the head (earliest finish)
    for (genvar g = 0; g < MAX_INTERVALS; g++) begin : g_cell
        logic                 left_valid;
        logic                 left_after;
        logic [TIME_BITS-1:0] left_start;
        logic [TIME_BITS-1:0] left_end;
        logic                 right_valid;
        logic [TIME_BITS-1:0] right_start;
        logic [TIME_BITS-1:0] right_end;

        if (g == 0) begin : g_head
            assign left_valid = 1'b0;
            assign left_after = 1'b0;
            assign left_start = '0;
            assign left_end   = '0;
        end else begin : g_mid
            assign left_valid = c_valid[g-1];
            assign left_after = c_after[g-1];
            assign left_start = c_start[g-1];
            assign left_end   = c_end[g-1];
        end

        if (g == MAX_INTERVALS - 1) begin : g_tail
            assign right_valid = 1'b0;
            assign right_start = '0;
            assign right_end   = '0;
        end else begin : g_body
            assign right_valid = c_valid[g+1];
            assign right_start = c_start[g+1];
            assign right_end   = c_end[g+1];
        end

        ismc_cell #(
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (ctrl),
            .i_new_start   (i_start_time),
            .i_new_end     (i_end_time),
            .i_left_valid  (left_valid),
            .i_left_after  (left_after),
            .i_left_start  (left_start),
            .i_left_end    (left_end),
            .i_right_valid (right_valid),
            .i_right_start (right_start),
            .i_right_end   (right_end),
            .o_valid       (c_valid[g]),
            .o_start       (c_start[g]),
            .o_end         (c_end[g]),
            .o_after       (c_after[g])
        );
    end

    ismc_scan #(
        .TIME_BITS (TIME_BITS),
        .CNT_W     (CNT_W)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (scan_start),
        .i_pop        (ctrl.pop),
        .i_head_start (c_start[0]),
        .i_head_end   (c_end[0]),
        .o_taken      (taken)
    );

endmodule

// ===== hw/rtl/ismc_checker.sv =====
// Port-level checks for the interval scheduler, bound to its top level.
// Depends on interval_scheduling_max_count_top_macros.svh.
`include "interval_scheduling_max_count_top_macros.svh"

module ismc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_last,
    input logic        o_valid,
    input logic        i_stall,
    input logic [10:0] o_meeting_count,
    input logic        o_overflow
);

    // a closed set always yields at least one interval
    `ISMC_ASSERT_IMP(a_count_nonzero, i_clk, i_rst_n, o_valid, o_meeting_count != 11'd0, "zero count")

    // closing word starts the drain, input must stall next cycle
    `ISMC_ASSERT_NXT(a_stall_after_last, i_clk, i_rst_n, i_valid && !o_stall && i_last, o_stall, "no stall after last word")

    // a new result is only posted while the input side is held off
    `ISMC_ASSERT_IMP(a_post_while_stalled, i_clk, i_rst_n, $rose(o_valid), $past(o_stall), "result posted while loading")

    // a held result keeps its value
    `ISMC_ASSERT_NXT(a_result_held, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_meeting_count) && $stable(o_overflow), "result changed while stalled")

endmodule

bind interval_scheduling_max_count_top ismc_checker u_ismc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .i_last          (i_last),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_meeting_count (o_meeting_count),
    .o_overflow      (o_overflow)
);
